FILE: rtl/ccs_pkg.sv
// shared types, constants and helpers for the coulomb counter
`timescale 1ns / 1ps

package ccs_pkg;

    // field and register widths
    localparam int CHARGE_W  = 32;
    localparam int MV_W      = 18;
    localparam int MA_W      = 21;
    localparam int SOC_IN_W  = 14;
    localparam int SOC_W     = 17;
    localparam int MAH_W     = 32;
    localparam int CFG_W     = 16;
    localparam int EFF_W     = 14;
    localparam int CFG_IDX_W = 3;
    localparam int HOLD_W    = 16;

    // constant divider
    localparam int DIV_W     = 33;
    localparam int REM_W     = 5;
    localparam int DIV_CNT_W = 6;

    // soc unit
    localparam int N_W       = 48;
    localparam int MC_W      = MAH_W + EFF_W;
    localparam int CAPK_W    = 26;
    localparam int QUO_W     = SOC_W;
    localparam int SOC_CNT_W = 5;
    localparam int SETP_W    = 30;
    localparam int LIM_W     = 20;

    localparam logic [REM_W-1:0]    QUANTUM_C     = 5'd18;
    localparam logic [REM_W-1:0]    SET_DIVISOR   = 5'd10;
    localparam logic [MAH_W-1:0]    MAH_PER_QUANT = 32'd5;
    localparam logic [SOC_IN_W-1:0] SOC_FULL      = 14'd10000;
    localparam logic [SOC_W-1:0]    SOC_MAX       = 17'd99999;
    localparam logic [CAPK_W-1:0]   MAH_PER_AH    = 26'd1000;
    localparam logic [LIM_W-1:0]    CENTI_TO_MILLI = 20'd10;
    localparam logic signed [CHARGE_W-1:0] ANCHOR_LIM = 32'sd360000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_CV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_CA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFICIENCY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 3'd4;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_FULL_CV  = 16'd5520;
    localparam logic [CFG_W-1:0] RST_TAIL_CA  = 16'd400;
    localparam logic [CFG_W-1:0] RST_CAPACITY = 16'd280;
    localparam logic [EFF_W-1:0] RST_EFF      = 14'd9900;
    localparam logic [CFG_W-1:0] RST_TICKS    = 16'd90;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_CALC,
        ST_DONE
    } ccs_state_t;

    typedef enum logic [1:0] {
        SP_IDLE,
        SP_MUL,
        SP_CHK,
        SP_DIV
    } ccs_soc_phase_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [REM_W-1:0] divisor;
    } ccs_div_req_t;

    function automatic logic [CAPK_W-1:0] cap_to_mah(input logic [CFG_W-1:0] cap);
        return CAPK_W'({{(CAPK_W-CFG_W){1'b0}}, cap} * MAH_PER_AH);
    endfunction

endpackage

FILE: rtl/ccs_cdiv.sv
// bit-serial restoring divider by a small divisor
`timescale 1ns / 1ps

module ccs_cdiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ccs_pkg::ccs_div_req_t          div_req,
    output logic                           busy,
    output logic [ccs_pkg::DIV_W-1:0]      quot,
    output logic [ccs_pkg::REM_W-1:0]      rem
);
    import ccs_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     num_reg, num_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [REM_W-1:0]     dsr_reg, dsr_next;
    logic [REM_W:0]       trial;
    logic                 take;

    always_comb
    begin
        trial     = {rem_reg, num_reg[DIV_W-1]};
        take      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (div_req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = div_req.dividend;
            rem_next  = '0;
            dsr_next  = div_req.divisor;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in behind the dividend
            rem_next = take ? REM_W'(trial - {1'b0, dsr_reg}) : trial[REM_W-1:0];
            num_next = {num_reg[DIV_W-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/ccs_soc.sv
// state of charge unit: serial multiply-accumulate then serial divide
`timescale 1ns / 1ps

module ccs_soc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ccs_pkg::MAH_W-1:0]     in_mah,
    input  logic [ccs_pkg::MAH_W-1:0]     out_mah,
    input  logic [ccs_pkg::EFF_W-1:0]     eff,
    input  logic [ccs_pkg::CAPK_W-1:0]    cap_mah,
    output logic                          busy,
    output logic [ccs_pkg::SOC_W-1:0]     soc
);
    import ccs_pkg::*;

    localparam int HI_W = N_W - 1 - QUO_W;

    ccs_soc_phase_t       phase_reg, phase_next;
    logic [SOC_CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]       acc_reg, acc_next;
    logic [MC_W-1:0]      mi_reg, mi_next;
    logic [MC_W-1:0]      mo_reg, mo_next;
    logic [EFF_W-1:0]     effsh_reg, effsh_next;
    logic [SOC_IN_W-1:0]  ksh_reg, ksh_next;
    logic [CAPK_W-1:0]    d_reg, d_next;
    logic [CAPK_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]     nlo_reg, nlo_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [HI_W-1:0]      hi;
    logic [CAPK_W:0]      trial;
    logic                 take;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mi_next    = mi_reg;
        mo_next    = mo_reg;
        effsh_next = effsh_reg;
        ksh_next   = ksh_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        quo_next   = quo_reg;
        hi         = acc_reg[N_W-2:QUO_W];
        trial      = {rem_reg, nlo_reg[QUO_W-1]};
        take       = trial >= {1'b0, d_reg};
        unique case (phase_reg)
            SP_IDLE:
            begin
                if (start)
                begin
                    acc_next   = '0;
                    mi_next    = MC_W'(in_mah);
                    mo_next    = MC_W'(out_mah);
                    effsh_next = eff;
                    ksh_next   = SOC_FULL;
                    d_next     = cap_mah;
                    cnt_next   = '0;
                    phase_next = SP_MUL;
                end
            end
            SP_MUL:
            begin
                // in * efficiency - out * 10000, one multiplier bit per cycle
                acc_next = acc_reg
                         + (effsh_reg[0] ? N_W'(mi_reg) : '0)
                         - (ksh_reg[0] ? N_W'(mo_reg) : '0);
                mi_next    = {mi_reg[MC_W-2:0], 1'b0};
                mo_next    = {mo_reg[MC_W-2:0], 1'b0};
                effsh_next = effsh_reg >> 1;
                ksh_next   = ksh_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == SOC_CNT_W'(EFF_W - 1))
                begin
                    phase_next = SP_CHK;
                end
            end
            SP_CHK:
            begin
                cnt_next = '0;
                if (acc_reg[N_W-1] || (acc_reg == '0))
                begin
                    quo_next   = '0;
                    phase_next = SP_IDLE;
                end
                else if (hi >= HI_W'(d_reg))
                begin
                    // quotient too large, or zero capacity
                    quo_next   = SOC_MAX;
                    phase_next = SP_IDLE;
                end
                else
                begin
                    rem_next   = hi[CAPK_W-1:0];
                    nlo_next   = acc_reg[QUO_W-1:0];
                    quo_next   = '0;
                    phase_next = SP_DIV;
                end
            end
            SP_DIV:
            begin
                rem_next = take ? CAPK_W'(trial - {1'b0, d_reg}) : trial[CAPK_W-1:0];
                nlo_next = {nlo_reg[QUO_W-2:0], 1'b0};
                quo_next = {quo_reg[QUO_W-2:0], take};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SOC_CNT_W'(QUO_W - 1))
                begin
                    phase_next = SP_IDLE;
                end
            end
            default:
            begin
                phase_next = SP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= SP_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mi_reg    <= mi_next;
        mo_reg    <= mo_next;
        effsh_reg <= effsh_next;
        ksh_reg   <= ksh_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        nlo_reg   <= nlo_next;
        quo_reg   <= quo_next;
    end

    assign busy = (phase_reg != SP_IDLE);
    assign soc  = (quo_reg > SOC_MAX) ? SOC_MAX : quo_reg;

endmodule

FILE: rtl/coulomb_counter_soc.sv
// coulomb counter with state of charge estimate, top level
`timescale 1ns / 1ps

// Usage:
// Input channel: sample or set-SOC items on in_valid / in_stall; a transfer
// happens when in_valid is high and in_stall is low. in_stall is high while
// an item is being worked on, so one item is in flight at a time.
// Output channel: one result per item on out_valid / out_stall, held in an
// output register; the next item may be taken while a result waits there.
// The 33-bit bit-serial divider (charge quantum, or setpoint scaling) sets
// the time from input transfer to out_valid; the SOC multiply and divide
// unit runs beside it and finishes earlier. A new item is taken only after
// the last result is loaded into the output register.
// A stalled result holds the block in its final step; the counters change
// only when the result register is loaded.
// Reset: counters, anchor and hold count clear, configuration takes its
// defaults. Configuration writes through cfg_we / cfg_index / cfg_data take
// effect at once; indexes past the register list are ignored.

module coulomb_counter_soc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccs_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [ccs_pkg::CHARGE_W-1:0]      charge_reading,
    input  logic [ccs_pkg::MV_W-1:0]          bus_millivolts,
    input  logic [ccs_pkg::MA_W-1:0]          current_milliamps,
    input  logic [ccs_pkg::SOC_IN_W-1:0]      soc_setpoint,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ccs_pkg::SOC_W-1:0]         soc_hundredths,
    output logic [ccs_pkg::MAH_W-1:0]         charged_in_mah,
    output logic [ccs_pkg::MAH_W-1:0]         drawn_out_mah,
    output logic [ccs_pkg::MAH_W-1:0]         daily_in_mah,
    output logic [ccs_pkg::MAH_W-1:0]         daily_out_mah,
    output logic [ccs_pkg::MAH_W-1:0]         lifetime_in_mah,
    output logic [ccs_pkg::MAH_W-1:0]         lifetime_out_mah,
    output logic                              reset_charge_request,
    output logic                              full_charge_detected
);
    import ccs_pkg::*;

    ccs_state_t          state_reg, state_next;
    logic [CFG_W-1:0]    fcv_reg, fcv_next;
    logic [CFG_W-1:0]    tail_reg, tail_next;
    logic [CFG_W-1:0]    cap_reg, cap_next;
    logic [EFF_W-1:0]    eff_reg, eff_next;
    logic [CFG_W-1:0]    ticks_reg, ticks_next;

    logic [CHARGE_W-1:0] anchor_reg, anchor_next;
    logic [MAH_W-1:0]    in_mah_reg, in_mah_next;
    logic [MAH_W-1:0]    out_mah_reg, out_mah_next;
    logic [MAH_W-1:0]    life_in_reg, life_in_next;
    logic [MAH_W-1:0]    life_out_reg, life_out_next;
    logic [MAH_W-1:0]    day_in_reg, day_in_next;
    logic [MAH_W-1:0]    day_out_reg, day_out_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic                out_valid_reg, out_valid_next;

    logic                action_reg, action_next;
    logic [CHARGE_W-1:0] charge_reg, charge_next;
    logic [MV_W-1:0]     mv_reg, mv_next;
    logic [MA_W-1:0]     ma_reg, ma_next;
    logic                dir_pos_reg, dir_pos_next;
    logic [MAH_W-1:0]    amt_reg, amt_next;
    logic [CHARGE_W-1:0] anchor_tmp_reg, anchor_tmp_next;
    logic                count_en_reg, count_en_next;
    logic                qual_reg, qual_next;
    logic [SOC_W-1:0]    soc_out_reg, soc_out_next;
    logic                req_out_reg, req_out_next;
    logic                full_out_reg, full_out_next;

    ccs_div_req_t        div_req;
    logic                div_busy;
    logic [DIV_W-1:0]    div_quot;
    logic [REM_W-1:0]    div_rem;
    logic                soc_start;
    logic                soc_busy;
    logic [SOC_W-1:0]    soc_val;
    logic [CAPK_W-1:0]   cap_mah;

    logic                accept;
    logic [DIV_W-1:0]    diff;
    logic [DIV_W-1:0]    mag;
    logic [SOC_IN_W-1:0] sp_clamped;
    logic [SOC_IN_W-1:0] span;
    logic [SETP_W-1:0]   setprod;
    logic [MAH_W-1:0]    quant;
    logic [CHARGE_W-1:0] anc;
    logic [LIM_W-1:0]    volt_lim;
    logic [LIM_W-1:0]    tail_lim;
    logic                ma_pos;
    logic                in_add;
    logic                out_add;
    logic                anchor_ov;
    logic [HOLD_W-1:0]   hold_inc;
    logic                full_hit;
    logic                out_free;

    assign cap_mah  = cap_to_mah(cap_reg);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        // charge moved since the anchor, exact in 33 bits
        diff       = {charge_reading[CHARGE_W-1], charge_reading}
                   - {anchor_reg[CHARGE_W-1], anchor_reg};
        mag        = diff[DIV_W-1] ? (~diff + 1'b1) : diff;
        sp_clamped = (soc_setpoint > SOC_FULL) ? SOC_FULL : soc_setpoint;
        span       = SOC_FULL - sp_clamped;
        setprod    = SETP_W'({{(SETP_W-CFG_W){1'b0}}, cap_reg}
                           * {{(SETP_W-SOC_IN_W){1'b0}}, span});

        div_req.start    = accept;
        div_req.dividend = action ? DIV_W'(setprod) : mag;
        div_req.divisor  = action ? SET_DIVISOR : QUANTUM_C;
        soc_start        = accept;

        quant    = div_quot[MAH_W-1:0];
        anc      = dir_pos_reg ? (charge_reg - CHARGE_W'(div_rem))
                               : (charge_reg + CHARGE_W'(div_rem));
        volt_lim = LIM_W'(fcv_reg) * CENTI_TO_MILLI;
        tail_lim = LIM_W'(tail_reg) * CENTI_TO_MILLI;
        ma_pos   = !ma_reg[MA_W-1] && (ma_reg != '0);

        in_add    = count_en_reg && !dir_pos_reg;
        out_add   = count_en_reg && dir_pos_reg;
        anchor_ov = ($signed(anchor_tmp_reg) > ANCHOR_LIM)
                 || ($signed(anchor_tmp_reg) < -ANCHOR_LIM);
        hold_inc  = hold_reg + 1'b1;
        full_hit  = qual_reg && (hold_inc >= ticks_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        fcv_next        = fcv_reg;
        tail_next       = tail_reg;
        cap_next        = cap_reg;
        eff_next        = eff_reg;
        ticks_next      = ticks_reg;
        anchor_next     = anchor_reg;
        in_mah_next     = in_mah_reg;
        out_mah_next    = out_mah_reg;
        life_in_next    = life_in_reg;
        life_out_next   = life_out_reg;
        day_in_next     = day_in_reg;
        day_out_next    = day_out_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && out_stall;
        action_next     = action_reg;
        charge_next     = charge_reg;
        mv_next         = mv_reg;
        ma_next         = ma_reg;
        dir_pos_next    = dir_pos_reg;
        amt_next        = amt_reg;
        anchor_tmp_next = anchor_tmp_reg;
        count_en_next   = count_en_reg;
        qual_next       = qual_reg;
        soc_out_next    = soc_out_reg;
        req_out_next    = req_out_reg;
        full_out_next   = full_out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FULL_CV:    fcv_next   = cfg_data;
                CFG_TAIL_CA:    tail_next  = cfg_data;
                CFG_CAPACITY:   cap_next   = cfg_data;
                CFG_EFFICIENCY: eff_next   = cfg_data[EFF_W-1:0];
                CFG_TICKS:      ticks_next = cfg_data;
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next  = action;
                    charge_next  = charge_reading;
                    mv_next      = bus_millivolts;
                    ma_next      = current_milliamps;
                    dir_pos_next = !diff[DIV_W-1] && (diff != '0);
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!div_busy && !soc_busy)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                amt_next        = quant * MAH_PER_QUANT;
                count_en_next   = (mv_reg != '0) && (quant != '0);
                anchor_tmp_next = ((mv_reg != '0) && (quant != '0)) ? anc : anchor_reg;
                qual_next       = ({{(LIM_W-MV_W){1'b0}}, mv_reg} > volt_lim)
                               && ma_pos && (ma_reg[LIM_W-1:0] < tail_lim);
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    soc_out_next   = soc_val;
                    state_next     = ST_IDLE;
                    if (action_reg)
                    begin
                        in_mah_next   = MAH_W'(cap_mah);
                        out_mah_next  = quant;
                        req_out_next  = 1'b0;
                        full_out_next = 1'b0;
                    end
                    else
                    begin
                        in_mah_next   = in_mah_reg + (in_add ? amt_reg : '0);
                        life_in_next  = life_in_reg + (in_add ? amt_reg : '0);
                        day_in_next   = day_in_reg + (in_add ? amt_reg : '0);
                        out_mah_next  = out_mah_reg + (out_add ? amt_reg : '0);
                        life_out_next = life_out_reg + (out_add ? amt_reg : '0);
                        day_out_next  = day_out_reg + (out_add ? amt_reg : '0);
                        anchor_next   = (anchor_ov || full_hit) ? '0 : anchor_tmp_reg;
                        hold_next     = (qual_reg && !full_hit) ? hold_inc : '0;
                        req_out_next  = anchor_ov || full_hit;
                        full_out_next = full_hit;
                        if (full_hit)
                        begin
                            in_mah_next  = MAH_W'(cap_mah);
                            out_mah_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fcv_reg       <= RST_FULL_CV;
            tail_reg      <= RST_TAIL_CA;
            cap_reg       <= RST_CAPACITY;
            eff_reg       <= RST_EFF;
            ticks_reg     <= RST_TICKS;
            anchor_reg    <= '0;
            in_mah_reg    <= '0;
            out_mah_reg   <= '0;
            life_in_reg   <= '0;
            life_out_reg  <= '0;
            day_in_reg    <= '0;
            day_out_reg   <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcv_reg       <= fcv_next;
            tail_reg      <= tail_next;
            cap_reg       <= cap_next;
            eff_reg       <= eff_next;
            ticks_reg     <= ticks_next;
            anchor_reg    <= anchor_next;
            in_mah_reg    <= in_mah_next;
            out_mah_reg   <= out_mah_next;
            life_in_reg   <= life_in_next;
            life_out_reg  <= life_out_next;
            day_in_reg    <= day_in_next;
            day_out_reg   <= day_out_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        charge_reg     <= charge_next;
        mv_reg         <= mv_next;
        ma_reg         <= ma_next;
        dir_pos_reg    <= dir_pos_next;
        amt_reg        <= amt_next;
        anchor_tmp_reg <= anchor_tmp_next;
        count_en_reg   <= count_en_next;
        qual_reg       <= qual_next;
        soc_out_reg    <= soc_out_next;
        req_out_reg    <= req_out_next;
        full_out_reg   <= full_out_next;
    end

    ccs_cdiv u_cdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .busy    (div_busy),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    ccs_soc u_soc (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (soc_start),
        .in_mah  (in_mah_reg),
        .out_mah (out_mah_reg),
        .eff     (eff_reg),
        .cap_mah (cap_mah),
        .busy    (soc_busy),
        .soc     (soc_val)
    );

    // counters sit behind the result register and change only when it loads
    assign out_valid            = out_valid_reg;
    assign soc_hundredths       = soc_out_reg;
    assign charged_in_mah       = in_mah_reg;
    assign drawn_out_mah        = out_mah_reg;
    assign daily_in_mah         = day_in_reg;
    assign daily_out_mah        = day_out_reg;
    assign lifetime_in_mah      = life_in_reg;
    assign lifetime_out_mah     = life_out_reg;
    assign reset_charge_request = req_out_reg;
    assign full_charge_detected = full_out_reg;

`ifndef SYNTHESIS
    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!div_busy && !soc_busy))
        else $error("arithmetic unit busy while idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside final step");

    a_full_requests_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && full_out_reg) |-> req_out_reg)
        else $error("full charge without charge reset request");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN) && div_busy && soc_busy)
        else $error("transfer did not start the arithmetic units");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DONE) |=> $stable(in_mah_reg) && $stable(out_mah_reg))
        else $error("counters changed outside final step");
`endif

endmodule
